// ----- rtl/vrm_pkg.sv -----
// Package for the vector running median unit: constants and item types.
// No dependencies.
package vrm_pkg;

	localparam int unsigned COMPONENTS_DEF  = 4;
	localparam int unsigned MAX_SAMPLES_DEF = 1024;
	localparam int unsigned VAL_W           = 32;
	localparam int unsigned CNT_OUT_W       = 11;

	typedef struct packed {
		logic signed [VAL_W-1:0] sample_a;
		logic signed [VAL_W-1:0] sample_b;
		logic signed [VAL_W-1:0] sample_c;
		logic signed [VAL_W-1:0] sample_d;
	} sample_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] median_a;
		logic signed [VAL_W-1:0] median_b;
		logic signed [VAL_W-1:0] median_c;
		logic signed [VAL_W-1:0] median_d;
		logic [CNT_OUT_W-1:0]    held_count;
		logic                    store_full;
	} result_t;

	// Request from the sequencer to one component's row engine
	typedef struct packed {
		logic go;
		logic full;
	} row_cmd_t;

endpackage

// ----- rtl/vector_running_median_unit.sv -----
// Top level of the vector running median unit: handshake, count and row engines.
// Depends on vrm_pkg and vrm_row.
//
// Usage: drive an item on sample and pulse start while busy is low. busy rises
// at the accepting edge and stays high while each component row inserts the new
// value into its sorted memory, shifting larger entries up one place at a time.
// When all rows finish, busy falls as valid rises, and result is shown for one
// cycle with valid high.
// Busy time grows with the number of entries greater than the new value in
// the slowest row, through the read-compare-write loop over the row memory.
// A dropped item (store full) skips the insertion and goes straight to the
// median read. Items are handled one at a time.
// The receiver cannot stall: valid is high for exactly one cycle.
// Reset clears the sample count and control; the memories need no clearing
// since only written entries are ever used.
module vector_running_median_unit import vrm_pkg::*; #(
	parameter int unsigned COMPONENTS  = COMPONENTS_DEF,
	parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  sample_t sample,
	output logic    busy,
	output logic    valid,
	output result_t result
);

	localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

	logic [CW-1:0]           count_q;
	logic                    full_q;
	row_cmd_t                cmd;
	logic [COMPONENTS-1:0]   done;
	logic [COMPONENTS-1:0]   done_q;
	logic signed [VAL_W-1:0] med [COMPONENTS];
	logic signed [VAL_W-1:0] vals [4];
	logic                    full_now;

	assign full_now = (count_q == CW'(MAX_SAMPLES));
	assign cmd.go   = start && !busy;
	assign cmd.full = full_now;
	assign vals[0] = sample.sample_a;
	assign vals[1] = sample.sample_b;
	assign vals[2] = sample.sample_c;
	assign vals[3] = sample.sample_d;

	for (genvar c = 0; c < COMPONENTS; c++) begin : g_row
		vrm_row #(.MAX_SAMPLES(MAX_SAMPLES)) u_row (
			.clk(clk), .arst_n(arst_n), .cmd(cmd), .count(count_q),
			.value(vals[c]), .done(done[c]), .median(med[c])
		);
	end

	// Track the item in flight and gather row completions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy    <= 1'b0;
			valid   <= 1'b0;
			count_q <= '0;
			full_q  <= 1'b0;
			done_q  <= '0;
		end else begin
			valid <= 1'b0;
			if (cmd.go) begin
				busy   <= 1'b1;
				full_q <= full_now;
				done_q <= '0;
				if (!full_now) begin
					count_q <= count_q + CW'(1);
				end
			end else if (busy) begin
				if (&(done_q | done)) begin
					valid  <= 1'b1;
					busy   <= 1'b0;
				end
				done_q <= done_q | done;
			end
		end
	end

	// Assemble result; medians are held in each row until the next item
	always_comb begin
		result            = '0;
		result.median_a   = med[0];
		if (COMPONENTS > 1) result.median_b = med[1 % COMPONENTS];
		if (COMPONENTS > 2) result.median_c = med[2 % COMPONENTS];
		if (COMPONENTS > 3) result.median_d = med[3 % COMPONENTS];
		result.held_count = CNT_OUT_W'(count_q);
		result.store_full = full_q;
	end

endmodule

// ----- rtl/vrm_row.sv -----
// One component row: sorted value memory with insertion shifter and median readout.
// Depends on vrm_pkg.
module vrm_row import vrm_pkg::*; #(
	parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int unsigned AW = $clog2(MAX_SAMPLES),
	parameter int unsigned CW = $clog2(MAX_SAMPLES + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  row_cmd_t                cmd,
	input  logic [CW-1:0]           count,
	input  logic signed [VAL_W-1:0] value,
	output logic                    done,
	output logic signed [VAL_W-1:0] median
);

	typedef enum logic [2:0] {
		IDLE, SHIFT_RD, SHIFT_CK, MED_RD1, MED_RD2, MED_SUM
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           pos_q;      // current hole position
	logic [CW-1:0]           newcnt_q;
	logic signed [VAL_W-1:0] val_q;
	logic signed [VAL_W-1:0] lo_q;

	logic signed [VAL_W-1:0] mem [MAX_SAMPLES];
	logic signed [VAL_W-1:0] rd_q;
	logic                    we;
	logic [AW-1:0]           wa, ra;
	logic signed [VAL_W-1:0] wd;
	logic [CW-1:0]           half;
	logic signed [VAL_W:0]   sum;

	assign half = newcnt_q >> 1;
	assign sum  = {lo_q[VAL_W-1], lo_q} + {rd_q[VAL_W-1], rd_q};

	// Memory port control
	always_comb begin
		we = 1'b0;
		wa = pos_q[AW-1:0];
		wd = val_q;
		ra = AW'(pos_q - CW'(1));
		case (state_q)
			SHIFT_CK: begin
				we = 1'b1;
				if (pos_q != '0 && rd_q > val_q) begin
					wd = rd_q;
				end
			end
			MED_RD1: ra = newcnt_q[0] ? half[AW-1:0] : AW'(half - CW'(1));
			MED_RD2: ra = half[AW-1:0];
			default: ;
		endcase
	end

	// Single-port-write, registered-read memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	// Sequence the insertion (skipped when the store is full), then the median read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			done     <= 1'b0;
			val_q    <= '0;
			pos_q    <= '0;
			newcnt_q <= '0;
			lo_q     <= '0;
			median   <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				IDLE: begin
					if (cmd.go) begin
						val_q    <= value;
						pos_q    <= count;
						newcnt_q <= cmd.full ? count : count + CW'(1);
						state_q  <= cmd.full ? MED_RD1 : SHIFT_RD;
					end
				end
				SHIFT_RD: state_q <= SHIFT_CK;
				SHIFT_CK: begin
					if (pos_q != '0 && rd_q > val_q) begin
						pos_q   <= pos_q - CW'(1);
						state_q <= SHIFT_RD;
					end else begin
						state_q <= MED_RD1;
					end
				end
				MED_RD1: state_q <= MED_RD2;
				MED_RD2: begin
					lo_q    <= rd_q;
					state_q <= MED_SUM;
				end
				MED_SUM: begin
					median  <= newcnt_q[0] ? lo_q : sum[VAL_W:1];
					done    <= 1'b1;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ----- verif/vrm_checker.sv -----
// Checker for the vector running median unit: predicts per-component medians
// and compares each result item against the oldest prediction. Depends on vrm_pkg.
module vrm_checker import vrm_pkg::*; #(
	parameter int unsigned COMPONENTS  = COMPONENTS_DEF,
	parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic    clk,
	input  logic    start,
	input  logic    busy,
	input  sample_t sample,
	input  logic    valid,
	input  result_t result,
	output int      fail_count,
	output int      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	int          sorted_rows [4][$];
	int unsigned held;
	result_t     median_queue [$];

	initial fail_count = 0;
	assign pending = median_queue.size();

	// Median of one sorted row: middle value, or floor of the two-middle mean
	function automatic logic signed [31:0] row_median(int c);
		int unsigned            half;
		logic signed [32:0]     sum;
		half = held / 2;
		if (held == 0) return '0;
		if (held[0]) return sorted_rows[c][half];
		sum = 33'(signed'(sorted_rows[c][half-1])) + 33'(signed'(sorted_rows[c][half]));
		return sum[32:1];
	endfunction

	// Insert the item after equal values unless the store is full, and predict the result
	function automatic result_t predict_medians(sample_t s);
		result_t     r;
		int          vals [4];
		int unsigned pos;
		logic signed [31:0] m [4];
		vals = '{s.sample_a, s.sample_b, s.sample_c, s.sample_d};
		r = '0;
		r.store_full = (held >= MAX_SAMPLES);
		if (!r.store_full) begin
			for (int c = 0; c < COMPONENTS; c++) begin
				pos = sorted_rows[c].size();
				while (pos > 0 && sorted_rows[c][pos-1] > vals[c]) pos--;
				sorted_rows[c].insert(pos, vals[c]);
			end
			held++;
		end
		for (int c = 0; c < 4; c++) m[c] = (c < COMPONENTS) ? row_median(c) : '0;
		r.median_a   = m[0];
		r.median_b   = m[1];
		r.median_c   = m[2];
		r.median_d   = m[3];
		r.held_count = held[CNT_OUT_W-1:0];
		return r;
	endfunction

	initial held = 0;

	// Watch accepted items and strobed results
	always @(posedge clk) begin
		result_t e;
		if (start && !busy) median_queue = {median_queue, predict_medians(sample)};
		if (valid) begin
			if (median_queue.size() == 0) begin
				$display("%0t: result with no item waiting, actual %h", $time, result);
				fail_count++;
			end else begin
				e = median_queue.pop_front();
				if (e.median_a !== result.median_a) begin
					$display("%0t: median_a expected %h actual %h", $time,
						e.median_a, result.median_a);
					fail_count++;
				end
				if (e.median_b !== result.median_b) begin
					$display("%0t: median_b expected %h actual %h", $time,
						e.median_b, result.median_b);
					fail_count++;
				end
				if (e.median_c !== result.median_c) begin
					$display("%0t: median_c expected %h actual %h", $time,
						e.median_c, result.median_c);
					fail_count++;
				end
				if (e.median_d !== result.median_d) begin
					$display("%0t: median_d expected %h actual %h", $time,
						e.median_d, result.median_d);
					fail_count++;
				end
				if (e.held_count !== result.held_count) begin
					$display("%0t: held_count expected %0d actual %0d", $time,
						e.held_count, result.held_count);
					fail_count++;
				end
				if (e.store_full !== result.store_full) begin
					$display("%0t: store_full expected %b actual %b", $time,
						e.store_full, result.store_full);
					fail_count++;
				end
			end
		end
	end
endmodule

// ----- verif/tb.sv -----
// Testbench top for the vector running median unit: clock, reset and item stimulus.
// Depends on vrm_pkg, vector_running_median_unit and vrm_checker.
module tb;
	import vrm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [31:0] VMAX = 32'sh7fffffff;
	localparam logic signed [31:0] VMIN = 32'sh80000000;

	logic    clk, arst_n, start, busy, valid;
	sample_t sample;
	result_t result;
	int      fail_count, pending, sent, burst_left;

	vector_running_median_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .sample(sample),
		.busy(busy), .valid(valid), .result(result)
	);

	vrm_checker chk (
		.clk(clk), .start(start), .busy(busy), .sample(sample),
		.valid(valid), .result(result), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Send one item: at a new burst maybe idle a random while, wait out busy, then hold start for one edge
	task automatic send_item(sample_t s);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 25)) @(negedge clk);
		end
		burst_left--;
		while (busy) @(negedge clk);
		start  <= 1'b1;
		sample <= s;
		@(negedge clk);
		start  <= 1'b0;
		sent++;
	endtask

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 5))
			0:       return $urandom_range(0, 1) ? VMAX : VMIN;
			1:       return 32'(signed'($urandom_range(0, 8)) - 4);
			2:       return {{16{1'b0}}, 16'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
			default: return $urandom;
		endcase
	endfunction

	function automatic sample_t rand_sample();
		return '{rand_value(), rand_value(), rand_value(), rand_value()};
	endfunction

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		start = 0; sample = '0; sent = 0; burst_left = 0;
		arst_n = 0;
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: extremes, overflowing middle sums, floor rounding, ties
		send_item('{VMAX, VMIN, 32'sd0, -32'sd1});
		send_item('{VMAX, VMIN, -32'sd1, 32'sd0});
		send_item('{VMIN, VMAX, 32'sd1, -32'sd1});
		send_item('{VMIN, VMIN, 32'sd1, -32'sd1});
		send_item('{32'sd0, VMIN, -32'sd3, 32'sd2});
		send_item('{32'sd0, VMAX, -32'sd3, 32'sd2});
		send_item('{32'sd5, 32'sd5, 32'sd5, 32'sd5});
		send_item('{32'sd5, 32'sd5, 32'sd5, 32'sd5});
		send_item('{32'h55555555, 32'haaaaaaaa, 32'h0000ffff, 32'hffff0000});
		send_item('{32'haaaaaaaa, 32'h55555555, 32'hffff0000, 32'h0000ffff});
		for (int i = 0; i < 10; i++) send_item(rand_sample());

		// Random items
		for (int i = 0; i < 520; i++) send_item(rand_sample());

		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end
endmodule
